>>> src/bsdf_pkg.sv
// Package for the brush stroke dynamics filter.
// Holds the shared saturation helper, register indexes and the iterative
// unit command type. No dependencies.
package bsdf_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] REG_MASS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRAG  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE = 2'd3;

	localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
	localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

	typedef struct packed {
		logic start;
		logic sqrt_op;
	} bsdf_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		if (v > SAT_HI) begin
			return 32'sh7fffffff;
		end else if (v < SAT_LO) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

>>> src/bsdf_if.sv
// Channel interfaces of the brush stroke dynamics filter.
// Depends on bsdf_pkg for the configuration field widths.
interface bsdf_in_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	modport source (output valid, action, pos_x, pos_y, input ready);
	modport sink (input valid, action, pos_x, pos_y, output ready);
endinterface

interface bsdf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] corner1_x;
	logic signed [31:0] corner1_y;
	logic signed [31:0] corner2_x;
	logic signed [31:0] corner2_y;
	logic signed [31:0] corner3_x;
	logic signed [31:0] corner3_y;
	logic signed [31:0] corner4_x;
	logic signed [31:0] corner4_y;
	logic [30:0]        speed;
	logic               still_active;
	modport source (output valid, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x,
		corner3_y, corner4_x, corner4_y, speed, still_active, input ready);
	modport sink (input valid, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x,
		corner3_y, corner4_x, corner4_y, speed, still_active, output ready);
endinterface

interface bsdf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bsdf_pkg::CFG_IDX_W-1:0]   index;
	logic [bsdf_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/bsdf_divsqrt.sv
// Shared iterative unit: 64-step restoring divider (64 by 32 bits) and
// 32-step integer square root of a 64-bit value, one step per cycle.
// Depends on bsdf_pkg.
module bsdf_divsqrt
	import bsdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bsdf_cmd_t   cmd,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [63:0] result
);

	logic        busy_q;
	logic        done_q;
	logic        op_q;
	logic [6:0]  cnt_q;
	logic [63:0] a_q;
	logic [63:0] r_q;
	logic [63:0] b_q;
	logic [31:0] den_q;

	logic [32:0] t_c;
	logic        dge_c;
	logic [63:0] rb_c;
	logic        sge_c;

	assign t_c   = {r_q[31:0], a_q[63]};
	assign dge_c = t_c >= {1'b0, den_q};
	assign rb_c  = r_q + b_q;
	assign sge_c = a_q >= rb_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.sqrt_op;
				cnt_q  <= cmd.sqrt_op ? 7'd32 : 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= num;
			r_q   <= '0;
			b_q   <= 64'h4000_0000_0000_0000;
			den_q <= den;
		end else if (busy_q) begin
			if (op_q) begin
				if (sge_c) begin
					a_q <= a_q - rb_c;
					r_q <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
			end else begin
				a_q <= {a_q[62:0], dge_c};
				r_q <= {31'b0, (dge_c ? t_c - {1'b0, den_q} : t_c)};
			end
		end
	end

	assign done   = done_q;
	assign result = op_q ? r_q : a_q;

endmodule

>>> src/brush_stroke_dynamics_filter.sv
// Top level of the brush stroke dynamics filter: sequencer, state and
// the shared multiplier. Depends on bsdf_pkg, bsdf_if and bsdf_divsqrt.
//
// Usage. Pointer words enter on the sample channel (valid/ready). A word
// with action 0 starts a stroke: the pen tip is placed at the pointer, the
// velocity and the previous stroke deltas are cleared and the filter is
// armed; no word comes out. A word with action 1 while armed runs one
// filter step and yields one quad word on the quad channel: four corners,
// the speed and whether the filter stays armed. An update while disarmed
// is consumed silently. Registers are written on the cfg channel, which is
// always ready; write them only while the block is idle.
// Datapath. An update runs through one shared 36 by 36 multiplier and one
// serial divide/square-root unit. A full update with the velocity normal
// uses two square roots, four divisions and the multiply steps; with the
// fixed tool angle it uses two roots and two divisions; an update whose
// force is below epsilon uses one root and the width multiplies. The
// sample channel is ready only between items.
// Reset clears the filter state and loads the register defaults. If the
// quad receiver stalls, the result waits in the output register and the
// next update holds before its emit step until the word is taken.
module brush_stroke_dynamics_filter
	import bsdf_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input logic         clk,
	input logic         arst_n,
	bsdf_in_if.sink     sample,
	bsdf_out_if.source  quad,
	bsdf_cfg_if.sink    cfg
);

	localparam longint unsigned ONE_F    = 64'd1 << FRAC_BITS;
	localparam longint unsigned EPS_RAW  = (ONE_F + 64'd500000) / 64'd1000000;
	localparam longint unsigned EPS      = (EPS_RAW == 0) ? 64'd1 : EPS_RAW;
	localparam longint unsigned WMIN_RAW = (ONE_F + 64'd50000) / 64'd100000;
	localparam longint unsigned WMIN     = (WMIN_RAW == 0) ? 64'd1 : WMIN_RAW;
	localparam longint unsigned WBASE    = (ONE_F * 64'd4 + 64'd50) / 64'd100;
	localparam longint unsigned ANG_X    = (ONE_F * 64'd3 + 64'd2) / 64'd5;
	localparam longint unsigned ANG_Y    = (ONE_F + 64'd2) / 64'd5;
	localparam logic signed [71:0] HALF_F  = 72'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [71:0] HALF_16 = 72'sd32768;

	typedef enum logic [4:0] {
		S_IDLE, S_SQ_X, S_SQ_Y, S_ACC_GO, S_ACC_WAIT, S_DIVX_GO, S_DIVX_WAIT,
		S_DIVY_GO, S_DIVY_WAIT, S_VSQ_X, S_VSQ_Y, S_VM_GO, S_VM_WAIT,
		S_ANGX_GO, S_ANGX_WAIT, S_ANGY_GO, S_ANGY_WAIT, S_KEEP_MUL, S_DRAG_X,
		S_DRAG_Y, S_MOVE, S_WID_MUL, S_DX_MUL, S_DY_MUL, S_DY_DONE, S_EMIT
	} state_t;

	state_t state_q;

	logic [17:0] mass_setting_q;
	logic [16:0] drag_setting_q;
	logic [18:0] width_scale_q;
	logic        fixed_angle_q;

	logic signed [31:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic signed [31:0] vel_x_q, vel_y_q, vel_mag_q;
	logic signed [31:0] angle_x_q, angle_y_q, old_dx_q, old_dy_q;
	logic               active_q;

	logic signed [31:0] fx_q, fy_q, dx_q, dy_q;
	logic [63:0]        sq_q;
	logic signed [18:0] keep_q;
	logic signed [35:0] wid_q;
	logic signed [71:0] mul_q;

	logic                out_valid_q;
	logic signed [31:0]  c1x_q, c1y_q, c2x_q, c2y_q, c3x_q, c3y_q, c4x_q, c4y_q;
	logic [30:0]         speed_q;
	logic                still_q;

	bsdf_cmd_t          cmd;
	logic [63:0]        u_num;
	logic [31:0]        u_den;
	logic               u_done;
	logic [63:0]        u_res;

	logic signed [35:0] mul_a, mul_b;
	logic [31:0]        mass_c;
	logic [17:0]        drag_c;
	logic signed [18:0] keep_c;
	logic signed [71:0] wr_c;
	logic signed [35:0] wid_c;
	logic signed [31:0] vm_c;
	logic signed [31:0] rnd16_c, rndf_c;

	function automatic logic [32:0] abs33(input logic signed [31:0] v);
		return v[31] ? 33'(-34'(v)) : 33'(v);
	endfunction

	function automatic logic signed [71:0] qsign(input logic [63:0] q, input logic neg);
		return neg ? -$signed({8'b0, q}) : $signed({8'b0, q});
	endfunction

	bsdf_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.num    (u_num),
		.den    (u_den),
		.done   (u_done),
		.result (u_res)
	);

	assign mass_c  = 32'd65536 + 32'(mass_setting_q) * 32'd159;
	assign drag_c  = 18'((mul_q[35:0] + 36'd65536) >> 17);
	assign keep_c  = 19'sd65536 - $signed({1'b0, drag_c});
	assign wr_c    = (mul_q + HALF_16) >>> 16;
	assign wid_c   = (wr_c < $signed(72'(WMIN))) ? 36'(WMIN) : wr_c[35:0];
	assign vm_c    = (u_res > 64'h7fff_ffff) ? 32'sh7fffffff : u_res[31:0];
	assign rnd16_c = sat32((mul_q + HALF_16) >>> 16);
	assign rndf_c  = sat32((mul_q + HALF_F) >>> FRAC_BITS);

	// Operand selection for the shared multiplier and the serial unit.
	always_comb begin
		mul_a       = '0;
		mul_b       = '0;
		cmd.start   = 1'b0;
		cmd.sqrt_op = 1'b0;
		u_num       = '0;
		u_den       = mass_c;
		case (state_q)
			S_SQ_X: begin
				mul_a = 36'(fx_q);
				mul_b = 36'(fx_q);
			end
			S_SQ_Y: begin
				mul_a = 36'(fy_q);
				mul_b = 36'(fy_q);
			end
			S_VSQ_X: begin
				mul_a = 36'(vel_x_q);
				mul_b = 36'(vel_x_q);
			end
			S_VSQ_Y: begin
				mul_a = 36'(vel_y_q);
				mul_b = 36'(vel_y_q);
			end
			S_ACC_GO, S_VM_GO: begin
				cmd.start   = 1'b1;
				cmd.sqrt_op = 1'b1;
				u_num       = sq_q + mul_q[63:0];
			end
			S_DIVX_GO: begin
				cmd.start = 1'b1;
				u_num     = {15'b0, abs33(fx_q), 16'b0};
			end
			S_DIVY_GO: begin
				cmd.start = 1'b1;
				u_num     = {15'b0, abs33(fy_q), 16'b0};
			end
			S_ANGX_GO: begin
				cmd.start = 1'b1;
				u_num     = 64'(abs33(vel_y_q)) << FRAC_BITS;
				u_den     = vel_mag_q;
			end
			S_ANGY_GO: begin
				cmd.start = 1'b1;
				u_num     = 64'(abs33(vel_x_q)) << FRAC_BITS;
				u_den     = vel_mag_q;
			end
			S_KEEP_MUL: begin
				mul_a = $signed({19'b0, drag_setting_q});
				mul_b = $signed({19'b0, drag_setting_q});
			end
			S_DRAG_X: begin
				mul_a = 36'(vel_x_q);
				mul_b = 36'(keep_c);
			end
			S_DRAG_Y: begin
				mul_a = 36'(vel_y_q);
				mul_b = 36'(keep_q);
			end
			S_WID_MUL: begin
				mul_a = $signed(36'(WBASE)) - 36'(vel_mag_q);
				mul_b = $signed({17'b0, width_scale_q});
			end
			S_DX_MUL: begin
				mul_a = 36'(angle_x_q);
				mul_b = wid_c;
			end
			S_DY_MUL: begin
				mul_a = 36'(angle_y_q);
				mul_b = wid_q;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mass_setting_q <= 18'd32768;
			drag_setting_q <= 17'd9830;
			width_scale_q  <= 19'd98304;
			fixed_angle_q  <= 1'b1;
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			vel_x_q        <= '0;
			vel_y_q        <= '0;
			vel_mag_q      <= '0;
			angle_x_q      <= '0;
			angle_y_q      <= '0;
			old_dx_q       <= '0;
			old_dy_q       <= '0;
			active_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_MASS:  mass_setting_q <= cfg.data[17:0];
					REG_DRAG:  drag_setting_q <= cfg.data[16:0];
					REG_WIDTH: width_scale_q  <= cfg.data;
					REG_ANGLE: fixed_angle_q  <= cfg.data[0];
					default:   fixed_angle_q  <= fixed_angle_q;
				endcase
			end
			// The emit step owns the output valid while it runs.
			if (quad.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						if (!sample.action) begin
							cur_x_q  <= sample.pos_x;
							cur_y_q  <= sample.pos_y;
							prev_x_q <= sample.pos_x;
							prev_y_q <= sample.pos_y;
							vel_x_q  <= '0;
							vel_y_q  <= '0;
							old_dx_q <= '0;
							old_dy_q <= '0;
							active_q <= 1'b1;
						end else if (active_q) begin
							fx_q    <= sat32(72'(sample.pos_x) - 72'(cur_x_q));
							fy_q    <= sat32(72'(sample.pos_y) - 72'(cur_y_q));
							state_q <= S_SQ_X;
						end
					end
				end
				S_SQ_X: state_q <= S_SQ_Y;
				S_SQ_Y: begin
					sq_q    <= mul_q[63:0];
					state_q <= S_ACC_GO;
				end
				S_ACC_GO: state_q <= S_ACC_WAIT;
				S_ACC_WAIT: begin
					if (u_done) begin
						// A force below epsilon stops the filter without moving.
						if (u_res < EPS) begin
							active_q <= 1'b0;
							state_q  <= S_WID_MUL;
						end else begin
							state_q <= S_DIVX_GO;
						end
					end
				end
				S_DIVX_GO: state_q <= S_DIVX_WAIT;
				S_DIVX_WAIT: begin
					if (u_done) begin
						vel_x_q <= sat32(qsign(u_res, fx_q[31]) + 72'(vel_x_q));
						state_q <= S_DIVY_GO;
					end
				end
				S_DIVY_GO: state_q <= S_DIVY_WAIT;
				S_DIVY_WAIT: begin
					if (u_done) begin
						vel_y_q <= sat32(qsign(u_res, fy_q[31]) + 72'(vel_y_q));
						state_q <= S_VSQ_X;
					end
				end
				S_VSQ_X: state_q <= S_VSQ_Y;
				S_VSQ_Y: begin
					sq_q    <= mul_q[63:0];
					state_q <= S_VM_GO;
				end
				S_VM_GO: state_q <= S_VM_WAIT;
				S_VM_WAIT: begin
					if (u_done) begin
						vel_mag_q <= vm_c;
						if ($unsigned(vm_c) < EPS) begin
							// Slow pen: the unnormalized normal becomes the angle.
							angle_x_q <= sat32(-72'(vel_y_q));
							angle_y_q <= vel_x_q;
							active_q  <= 1'b0;
							state_q   <= S_WID_MUL;
						end else if (fixed_angle_q) begin
							angle_x_q <= 32'(ANG_X);
							angle_y_q <= 32'(ANG_Y);
							state_q   <= S_KEEP_MUL;
						end else begin
							state_q <= S_ANGX_GO;
						end
					end
				end
				S_ANGX_GO: state_q <= S_ANGX_WAIT;
				S_ANGX_WAIT: begin
					if (u_done) begin
						angle_x_q <= sat32(qsign(u_res, !vel_y_q[31]));
						state_q   <= S_ANGY_GO;
					end
				end
				S_ANGY_GO: state_q <= S_ANGY_WAIT;
				S_ANGY_WAIT: begin
					if (u_done) begin
						angle_y_q <= sat32(qsign(u_res, vel_x_q[31]));
						state_q   <= S_KEEP_MUL;
					end
				end
				S_KEEP_MUL: state_q <= S_DRAG_X;
				S_DRAG_X: begin
					keep_q  <= keep_c;
					state_q <= S_DRAG_Y;
				end
				S_DRAG_Y: begin
					vel_x_q <= rnd16_c;
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					vel_y_q  <= rnd16_c;
					prev_x_q <= cur_x_q;
					prev_y_q <= cur_y_q;
					cur_x_q  <= sat32(72'(cur_x_q) + 72'(vel_x_q));
					cur_y_q  <= sat32(72'(cur_y_q) + 72'(rnd16_c));
					state_q  <= S_WID_MUL;
				end
				S_WID_MUL: state_q <= S_DX_MUL;
				S_DX_MUL: begin
					wid_q   <= wid_c;
					state_q <= S_DY_MUL;
				end
				S_DY_MUL: begin
					dx_q    <= rndf_c;
					state_q <= S_DY_DONE;
				end
				S_DY_DONE: begin
					dy_q    <= rndf_c;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// Hold until the output register is free.
					if (!out_valid_q || quad.ready) begin
						c1x_q       <= sat32(72'(prev_x_q) + 72'(old_dx_q));
						c1y_q       <= sat32(72'(prev_y_q) + 72'(old_dy_q));
						c2x_q       <= sat32(72'(prev_x_q) - 72'(old_dx_q));
						c2y_q       <= sat32(72'(prev_y_q) - 72'(old_dy_q));
						c3x_q       <= sat32(72'(cur_x_q) - 72'(dx_q));
						c3y_q       <= sat32(72'(cur_y_q) - 72'(dy_q));
						c4x_q       <= sat32(72'(cur_x_q) + 72'(dx_q));
						c4y_q       <= sat32(72'(cur_y_q) + 72'(dy_q));
						speed_q     <= vel_mag_q[30:0];
						still_q     <= active_q;
						old_dx_q    <= dx_q;
						old_dy_q    <= dy_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;

	assign quad.valid        = out_valid_q;
	assign quad.corner1_x    = c1x_q;
	assign quad.corner1_y    = c1y_q;
	assign quad.corner2_x    = c2x_q;
	assign quad.corner2_y    = c2y_q;
	assign quad.corner3_x    = c3x_q;
	assign quad.corner3_y    = c3y_q;
	assign quad.corner4_x    = c4x_q;
	assign quad.corner4_y    = c4y_q;
	assign quad.speed        = speed_q;
	assign quad.still_active = still_q;

endmodule

>>> dv/brush_stroke_dynamics_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for brush_stroke_dynamics_filter.
// Depends on bsdf_pkg, the bsdf channel interfaces and the filter RTL.
module brush_stroke_dynamics_filter_tb;
	import bsdf_pkg::*;

	// Fixed-point constants of the default Q7.24 build.
	localparam int         FB        = 24;
	localparam longint     EPS_Q     = 17;
	localparam longint     WBASE_Q   = 671089;
	localparam longint     WMIN_Q    = 168;
	localparam longint     TOOL_AX   = 10066330;
	localparam longint     TOOL_AY   = 3355443;
	localparam int         WDOG_MAX  = 20000;
	localparam int         HOLD_LEN  = 3000;
	localparam int         DRAIN_LEN = 400;
	localparam logic       ACT_START = 1'b0;
	localparam logic       ACT_STEP  = 1'b1;
	localparam logic signed [31:0] PMAX = 32'sh7fffffff;
	localparam logic signed [31:0] PMIN = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] c1x;
		logic signed [31:0] c1y;
		logic signed [31:0] c2x;
		logic signed [31:0] c2y;
		logic signed [31:0] c3x;
		logic signed [31:0] c3y;
		logic signed [31:0] c4x;
		logic signed [31:0] c4y;
		logic [30:0]        speed;
		logic               still;
	} quad_t;

	// What the stimulus side knows about one sample word: whether its quad is
	// typed in by hand rather than taken from the predictor.
	typedef struct {
		bit    hand;
		quad_t q;
	} hint_t;

	typedef struct {
		logic              action;
		logic signed [31:0] x;
		logic signed [31:0] y;
		bit                hand;
		quad_t             q;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bsdf_in_if  sample_ch();
	bsdf_out_if quad_ch();
	bsdf_cfg_if cfg_ch();

	brush_stroke_dynamics_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.quad   (quad_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always #5 clk = ~clk;

	// Filter state and register copies kept by the predictor.
	logic [17:0]        k_mass;
	logic [16:0]        k_drag;
	logic [18:0]        k_width;
	logic               k_tool;
	logic signed [31:0] tip_x, tip_y, last_x, last_y, v_x, v_y, v_mag;
	logic signed [31:0] dir_x, dir_y, od_x, od_y;
	bit                 armed;

	quad_t quads_due[$];
	hint_t hints[$];
	int    errors = 0;
	int    n_words = 0;
	int    n_quads = 0;
	int    n_stops = 0;
	int    n_cfg = 0;
	int    idle_cycles = 0;
	bit    hold_req = 0;
	bit    calm = 0;

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return PMAX;
		if (v < -64'sd2147483648) return PMIN;
		return v[31:0];
	endfunction

	// Floor of (v + half) / 2^s; the arithmetic shift floors toward -inf.
	function automatic longint round_shift(input longint v, input int s);
		longint t;
		t = v + (64'sd1 <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void reset_state();
		k_mass = 18'd32768;
		k_drag = 17'd9830;
		k_width = 19'd98304;
		k_tool = 1'b1;
		tip_x = 0; tip_y = 0; last_x = 0; last_y = 0;
		v_x = 0; v_y = 0; v_mag = 0;
		dir_x = 0; dir_y = 0; od_x = 0; od_y = 0;
		armed = 0;
	endfunction

	// One spring-with-drag step toward the pointer. The early returns leave
	// the tip where it is: force too small, or speed too small to move.
	function automatic void pull_tip(input longint px, input longint py);
		longint mass, drag, keep, fx, fy, vx, vy, kd;
		longint unsigned acc, vm;
		mass = 65536 + 159 * longint'(k_mass);
		kd = longint'(k_drag);
		drag = (kd * kd + 65536) >>> 17;
		keep = 65536 - drag;
		fx = clamp32(px - tip_x);
		fy = clamp32(py - tip_y);
		acc = root64(longint'(fx * fx) + longint'(fy * fy));
		if (longint'(acc) < EPS_Q) begin
			armed = 0;
			return;
		end
		v_x = clamp32(longint'(v_x) + (fx * 65536) / mass);
		v_y = clamp32(longint'(v_y) + (fy * 65536) / mass);
		vx = v_x;
		vy = v_y;
		vm = root64(longint'(vx * vx) + longint'(vy * vy));
		v_mag = (vm > 64'd2147483647) ? PMAX : vm[31:0];
		if (longint'(v_mag) < EPS_Q) begin
			dir_x = clamp32(-vy);
			dir_y = clamp32(vx);
			armed = 0;
			return;
		end
		if (k_tool) begin
			dir_x = 32'(TOOL_AX);
			dir_y = 32'(TOOL_AY);
		end else begin
			dir_x = clamp32((-vy * (64'sd1 <<< FB)) / longint'(v_mag));
			dir_y = clamp32((vx * (64'sd1 <<< FB)) / longint'(v_mag));
		end
		v_x = clamp32(round_shift(vx * keep, 16));
		v_y = clamp32(round_shift(vy * keep, 16));
		last_x = tip_x;
		last_y = tip_y;
		tip_x = clamp32(longint'(tip_x) + v_x);
		tip_y = clamp32(longint'(tip_y) + v_y);
	endfunction

	// Builds the quad joining the old and the new cross-section of the stroke.
	function automatic quad_t stroke_quad();
		quad_t q;
		longint wid;
		logic signed [31:0] dx, dy;
		wid = round_shift((WBASE_Q - longint'(v_mag)) * longint'(k_width), 16);
		if (wid < WMIN_Q) wid = WMIN_Q;
		dx = clamp32(round_shift(longint'(dir_x) * wid, FB));
		dy = clamp32(round_shift(longint'(dir_y) * wid, FB));
		q.c1x = clamp32(longint'(last_x) + od_x);
		q.c1y = clamp32(longint'(last_y) + od_y);
		q.c2x = clamp32(longint'(last_x) - od_x);
		q.c2y = clamp32(longint'(last_y) - od_y);
		q.c3x = clamp32(longint'(tip_x) - dx);
		q.c3y = clamp32(longint'(tip_y) - dy);
		q.c4x = clamp32(longint'(tip_x) + dx);
		q.c4y = clamp32(longint'(tip_y) + dy);
		od_x = dx;
		od_y = dy;
		q.speed = v_mag[30:0];
		q.still = armed;
		return q;
	endfunction

	// Returns 1 and the quad when the word produces one.
	function automatic bit filter_word(input logic action, input logic signed [31:0] px,
		input logic signed [31:0] py, output quad_t q);
		q = '0;
		if (action == ACT_START) begin
			tip_x = px; last_x = px;
			tip_y = py; last_y = py;
			v_x = 0; v_y = 0; od_x = 0; od_y = 0;
			armed = 1;
			return 0;
		end
		if (!armed) return 0;
		pull_tip(px, py);
		q = stroke_quad();
		return 1;
	endfunction

	function automatic void write_reg(input logic [1:0] idx, input logic [18:0] val);
		case (idx)
			REG_MASS: begin
				k_mass = val[17:0];
			end
			REG_DRAG: begin
				k_drag = val[16:0];
			end
			REG_WIDTH: begin
				k_width = val;
			end
			REG_ANGLE: begin
				k_tool = val[0];
			end
			default: begin
				k_tool = k_tool;
			end
		endcase
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	// Input side: every accepted word runs through the predictor, and every
	// accepted register write updates the register copies.
	always @(posedge clk) begin
		quad_t q;
		hint_t h;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			h = hints.pop_front();
			n_words++;
			if (filter_word(sample_ch.action, sample_ch.pos_x, sample_ch.pos_y, q)) begin
				quads_due.push_back(h.hand ? h.q : q);
			end
		end
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			write_reg(cfg_ch.index, cfg_ch.data);
			n_cfg++;
		end
	end

	// Output side: every accepted quad word is compared with the oldest
	// expectation.
	always @(posedge clk) begin
		quad_t w;
		if (arst_n && quad_ch.valid && quad_ch.ready) begin
			n_quads++;
			if (!quad_ch.still_active) n_stops++;
			if (quads_due.size() == 0) begin
				$error("quad word arrived with no expectation pending");
				errors++;
			end else begin
				w = quads_due.pop_front();
				check_field("corner1_x", w.c1x, quad_ch.corner1_x);
				check_field("corner1_y", w.c1y, quad_ch.corner1_y);
				check_field("corner2_x", w.c2x, quad_ch.corner2_x);
				check_field("corner2_y", w.c2y, quad_ch.corner2_y);
				check_field("corner3_x", w.c3x, quad_ch.corner3_x);
				check_field("corner3_y", w.c3y, quad_ch.corner3_y);
				check_field("corner4_x", w.c4x, quad_ch.corner4_x);
				check_field("corner4_y", w.c4y, quad_ch.corner4_y);
				check_field("speed", {1'b0, w.speed}, {1'b0, quad_ch.speed});
				check_field("still_active", {31'd0, w.still}, {31'd0, quad_ch.still_active});
			end
		end
	end

	// Watchdog: too long without any handshake means the block hung.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (quad_ch.valid && quad_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > WDOG_MAX) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Quad receiver: random stalls, plus one long hold-off on request so the
	// block backs up and stalls the sample channel.
	initial begin
		quad_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int g;
			g = pick_gap();
			if (hold_req) begin
				quad_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 0;
			end else if (g > 0) begin
				quad_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end else begin
				quad_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one sample word and returns after it is accepted. Valid stays
	// high into the next word when there is no gap.
	task automatic send_word(input logic action, input logic signed [31:0] px,
		input logic signed [31:0] py, input bit hand, input quad_t q);
		hint_t h;
		int g;
		h.hand = hand;
		h.q = q;
		hints.push_back(h);
		sample_ch.valid <= 1'b1;
		sample_ch.action <= action;
		sample_ch.pos_x <= px;
		sample_ch.pos_y <= py;
		do @(posedge clk); while (!sample_ch.ready);
		g = pick_gap();
		if (g > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [18:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for all quads, then for the slowest silent update to finish.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (quads_due.size() != 0) @(posedge clk);
		repeat (DRAIN_LEN) @(posedge clk);
	endtask

	function automatic logic signed [31:0] near(input logic signed [31:0] base);
		int sh;
		longint d;
		sh = $urandom_range(0, 30);
		d = longint'($urandom_range(0, 2 ** 16)) <<< sh >>> 16;
		if ($urandom_range(0, 1)) d = -d;
		return clamp32(longint'(base) + d);
	endfunction

	// Random words: mostly a start followed by a run of updates near the
	// pointer, which keeps the filter armed; the rest is raw noise.
	task automatic random_words(input int count);
		int sent;
		int run;
		logic signed [31:0] bx, by;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 85) begin
				bx = $urandom_range(0, 3) == 0 ? $urandom() : near(0);
				by = $urandom_range(0, 3) == 0 ? $urandom() : near(0);
				send_word(ACT_START, bx, by, 0, '0);
				sent++;
				run = $urandom_range(1, 12);
				repeat (run) begin
					bx = near(bx);
					by = near(by);
					send_word(ACT_STEP, bx, by, 0, '0);
					sent++;
				end
			end else begin
				send_word(1'($urandom_range(0, 1)), $urandom(), $urandom(), 0, '0);
				sent++;
			end
		end
	endtask

	row_t rows[$];
	logic [18:0] settings[5][4];

	initial begin
		quad_t zq;
		sample_ch.valid = 1'b0;
		sample_ch.action = ACT_START;
		sample_ch.pos_x = '0;
		sample_ch.pos_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MASS;
		cfg_ch.data = '0;
		reset_state();
		zq = '0;

		// Directed rows. Only the quad of an update at rest right after reset
		// is typed in: all corners, the speed and the armed flag are zero.
		rows.push_back('{ACT_STEP, 0, 0, 0, zq});
		rows.push_back('{ACT_START, 0, 0, 0, zq});
		rows.push_back('{ACT_STEP, 0, 0, 1, zq});
		rows.push_back('{ACT_STEP, 0, 0, 0, zq});
		rows.push_back('{ACT_START, PMAX, PMAX, 0, zq});
		rows.push_back('{ACT_STEP, PMIN, PMIN, 0, zq});
		rows.push_back('{ACT_STEP, PMIN, PMAX, 0, zq});
		rows.push_back('{ACT_START, PMIN, PMIN, 0, zq});
		rows.push_back('{ACT_STEP, PMAX, PMAX, 0, zq});
		// Force just above epsilon but too weak to build any speed.
		rows.push_back('{ACT_START, 0, 0, 0, zq});
		rows.push_back('{ACT_STEP, 20, 0, 0, zq});
		// Force below epsilon.
		rows.push_back('{ACT_START, 5, 5, 0, zq});
		rows.push_back('{ACT_STEP, 15, 5, 0, zq});
		// A normal stroke that keeps moving.
		rows.push_back('{ACT_START, 0, 0, 0, zq});
		rows.push_back('{ACT_STEP, 32'sh01000000, 0, 0, zq});
		rows.push_back('{ACT_STEP, 32'sh01000000, 32'sh01000000, 0, zq});
		rows.push_back('{ACT_STEP, -1, -1, 0, zq});
		rows.push_back('{ACT_STEP, 32'sh55555555, 32'shaaaaaaaa, 0, zq});
		rows.push_back('{ACT_STEP, 32'shaaaaaaaa, 32'sh55555555, 0, zq});
		rows.push_back('{ACT_START, 32'sh55555555, 32'shaaaaaaaa, 0, zq});
		rows.push_back('{ACT_STEP, 32'sh55555555, 32'shaaaaaaaa, 0, zq});

		// Register settings per random phase: all zero, top of range, all
		// bits set beyond range, a random legal mix, and back to defaults
		// with the fixed tool angle.
		settings[0] = '{0, 0, 0, 0};
		settings[1] = '{196608, 65536, 327680, 1};
		settings[2] = '{19'h3ffff, 19'h1ffff, 19'h7ffff, 0};
		settings[3] = '{19'($urandom_range(0, 196608)), 19'($urandom_range(0, 65536)),
			19'($urandom_range(0, 327680)), 0};
		settings[4] = '{32768, 9830, 98304, 1};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_word(rows[i].action, rows[i].x, rows[i].y, rows[i].hand, rows[i].q);
		end
		drain();

		for (int p = 0; p < 5; p++) begin
			cfg_write(REG_MASS, settings[p][0]);
			cfg_write(REG_DRAG, settings[p][1]);
			cfg_write(REG_WIDTH, settings[p][2]);
			cfg_write(REG_ANGLE, settings[p][3]);
			// One phase runs with no idling on either side, one carries the
			// long receiver hold-off.
			calm = (p == 2);
			if (p == 1) hold_req = 1;
			random_words(240);
			drain();
		end

		$display("Covered %0d sample words, %0d quads (%0d ending a stroke), %0d writes",
			n_words, n_quads, n_stops, n_cfg);
		$display("across five register settings with random stalls and one long hold-off.");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/bsdf_pkg.sv
src/bsdf_if.sv
src/bsdf_divsqrt.sv
src/brush_stroke_dynamics_filter.sv
dv/brush_stroke_dynamics_filter_tb.sv
